>>> rtl/hash_set_sorted_buckets_macros.svh
// Assertion macros for the hash set block
`ifndef HASH_SET_SORTED_BUCKETS_MACROS_SVH
`define HASH_SET_SORTED_BUCKETS_MACROS_SVH
// Implication checked on every edge outside reset
`define HSSB_ASSERT_IMP(lbl, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset
`define HSSB_ASSERT_NXT(lbl, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/hssb_pkg.sv
//------------------------------------------------------------------------------
// hssb_pkg
// Types, constants and hash helpers for the sorted-bucket hash set.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hssb_pkg;
	localparam int MAX_BUCKETS  = 16;
	localparam int BUCKET_DEPTH = 16;
	localparam int BW  = $clog2(MAX_BUCKETS);
	localparam int DW  = $clog2(BUCKET_DEPTH);
	localparam int AW  = BW + DW;
	localparam int FW  = 5;
	localparam logic [63:0] MIX_ADD = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_M1  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_M2  = 64'h94D049BB133111EB;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_TEST  = 2'd1,
		OP_DEL   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOCHG = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_MOD,
		S_FILL,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_CHK_RD,
		S_CHK_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t         opcode;
		logic [63:0] key;
	} in_t;

	typedef struct packed {
		logic    found;
		status_t status;
		logic [4:0] fill_after;
	} out_t;
endpackage
`default_nettype wire

>>> rtl/hash_set_sorted_buckets.sv
//------------------------------------------------------------------------------
// hash_set_sorted_buckets
// Set of 64-bit keys in hashed buckets, each sorted, searched by bisection.
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   hssb_pkg::in_t
// res      out  res_valid/res_stall hssb_pkg::out_t
// cfg      in   cfg_we              cfg_data[4:0]
//
// One item at a time, in order: the hash on a shared 64x16 multiplier, the modulo
// (8 remainder bits per cycle), a bisection of at most 5 steps, a shift of at most
// 15 entries and, when a key is inserted, the write of the key. A clear goes
// straight to its result.
// Reset clears fills and control and sets count to 1; the key memory is not cleared.
// in_stall is high while an item is in work or its result waits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hash_set_sorted_buckets_macros.svh"
module hash_set_sorted_buckets (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire hssb_pkg::in_t   in_data,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output hssb_pkg::out_t       res_data,
	input  wire logic            cfg_we,
	input  wire logic [4:0]      cfg_data
);
	hssb_pkg::state_t state_q, state_d;
	logic [4:0] count_q;
	logic [hssb_pkg::FW-1:0] fill_q [hssb_pkg::MAX_BUCKETS];
	logic [63:0] mem [hssb_pkg::MAX_BUCKETS*hssb_pkg::BUCKET_DEPTH];
	logic [63:0] rd_q;
	hssb_pkg::op_t op_q;
	logic [63:0] key_q, z_q, acc_q;
	logic [1:0]  part_q;
	logic        pass_q;
	logic [2:0]  cnt_q;
	logic [4:0]  rem_q, rem_d;
	logic [5:0]  rem_t;
	logic [hssb_pkg::BW-1:0] bkt_q;
	logic [hssb_pkg::FW-1:0] len_q, lo_q, hi_q, idx_q;
	logic        hit;
	hssb_pkg::out_t res_q;
	logic [4:0]  nb;
	logic [hssb_pkg::FW-1:0] mid, fill_sel, idx_m1, idx_p1;
	logic [hssb_pkg::AW-1:0] rd_addr;
	logic [79:0] prod;
	logic [63:0] mixin;
	logic [63:0] mconst;
	logic [63:0] mul_sum;

	always_comb begin
		nb = (count_q == 5'd0) ? 5'd1 :
			(count_q > 5'(hssb_pkg::MAX_BUCKETS)) ? 5'(hssb_pkg::MAX_BUCKETS) : count_q;
	end

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_m1 = idx_q - 5'd1;
	assign idx_p1 = idx_q + 5'd1;
	assign mixin  = pass_q ? (z_q ^ (z_q >> 27)) : (z_q ^ (z_q >> 30));
	assign mconst = pass_q ? hssb_pkg::MIX_M2 : hssb_pkg::MIX_M1;
	assign prod = {16'd0, mixin} * {64'd0, mconst[part_q*16 +: 16]};
	assign mul_sum = acc_q + (prod[63:0] << {part_q, 4'd0});
	assign hit = (lo_q < len_q) && (rd_q == key_q);
	assign fill_sel = (fill_q[rem_q[hssb_pkg::BW-1:0]] > 5'(hssb_pkg::BUCKET_DEPTH)) ?
		5'(hssb_pkg::BUCKET_DEPTH) : fill_q[rem_q[hssb_pkg::BW-1:0]];

	always_comb begin
		rem_d = rem_q;
		rem_t = '0;
		for (int j = 0; j < 8; j++) begin
			rem_t = {rem_d, z_q[63-j]};
			if (rem_t >= {1'b0, nb}) rem_t = rem_t - {1'b0, nb};
			rem_d = rem_t[4:0];
		end
	end

	always_comb begin
		in_stall  = (state_q != hssb_pkg::S_IDLE);
		res_valid = (state_q == hssb_pkg::S_DONE);
		res_data  = res_q;
		unique case (state_q)
			hssb_pkg::S_SRCH_RD:  rd_addr = {bkt_q, mid[hssb_pkg::DW-1:0]};
			hssb_pkg::S_CHK_RD:   rd_addr = {bkt_q, lo_q[hssb_pkg::DW-1:0]};
			hssb_pkg::S_SHIFT_RD: rd_addr = (op_q == hssb_pkg::OP_ADD) ?
				{bkt_q, idx_m1[hssb_pkg::DW-1:0]} : {bkt_q, idx_p1[hssb_pkg::DW-1:0]};
			default:              rd_addr = {bkt_q, idx_q[hssb_pkg::DW-1:0]};
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hssb_pkg::S_IDLE:
				if (in_valid) begin
					state_d = (in_data.opcode == hssb_pkg::OP_CLEAR) ?
						hssb_pkg::S_DONE : hssb_pkg::S_MUL;
				end
			hssb_pkg::S_MUL:
				if (pass_q && part_q == 2'd3) state_d = hssb_pkg::S_MOD;
			hssb_pkg::S_MOD:
				if (cnt_q == 3'd7) state_d = hssb_pkg::S_FILL;
			hssb_pkg::S_FILL:     state_d = hssb_pkg::S_SRCH_RD;
			hssb_pkg::S_SRCH_RD:
				state_d = (lo_q < hi_q) ? hssb_pkg::S_SRCH_CMP : hssb_pkg::S_CHK_RD;
			hssb_pkg::S_SRCH_CMP: state_d = hssb_pkg::S_SRCH_RD;
			hssb_pkg::S_CHK_RD:   state_d = hssb_pkg::S_CHK_CMP;
			hssb_pkg::S_CHK_CMP: begin
				if (op_q == hssb_pkg::OP_ADD) begin
					if (hit || len_q >= 5'(hssb_pkg::BUCKET_DEPTH)) state_d = hssb_pkg::S_DONE;
					else if (len_q == lo_q) state_d = hssb_pkg::S_INS;
					else state_d = hssb_pkg::S_SHIFT_RD;
				end else if (op_q == hssb_pkg::OP_DEL) begin
					if (!hit || lo_q + 5'd1 >= len_q) state_d = hssb_pkg::S_DONE;
					else state_d = hssb_pkg::S_SHIFT_RD;
				end else
					state_d = hssb_pkg::S_DONE;
			end
			hssb_pkg::S_SHIFT_RD: state_d = hssb_pkg::S_SHIFT_WR;
			hssb_pkg::S_SHIFT_WR: begin
				if (op_q == hssb_pkg::OP_ADD)
					state_d = (idx_m1 == lo_q) ? hssb_pkg::S_INS : hssb_pkg::S_SHIFT_RD;
				else
					state_d = (idx_q + 5'd2 >= len_q) ? hssb_pkg::S_DONE : hssb_pkg::S_SHIFT_RD;
			end
			hssb_pkg::S_INS:      state_d = hssb_pkg::S_DONE;
			hssb_pkg::S_DONE:
				if (!res_stall) state_d = hssb_pkg::S_IDLE;
			default:              state_d = hssb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hssb_pkg::S_IDLE;
			count_q <= 5'd1;
			for (int i = 0; i < hssb_pkg::MAX_BUCKETS; i++) fill_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) count_q <= cfg_data;
			if (state_q == hssb_pkg::S_IDLE && in_valid && in_data.opcode == hssb_pkg::OP_CLEAR)
				for (int i = 0; i < hssb_pkg::MAX_BUCKETS; i++) fill_q[i] <= '0;
			if (state_q == hssb_pkg::S_DONE && op_q != hssb_pkg::OP_CLEAR &&
				state_d == hssb_pkg::S_IDLE)
				fill_q[bkt_q] <= res_q.fill_after;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		unique case (state_q)
			hssb_pkg::S_IDLE: begin
				op_q   <= in_data.opcode;
				key_q  <= in_data.key;
				z_q    <= in_data.key + hssb_pkg::MIX_ADD;
				acc_q  <= '0;
				part_q <= 2'd0;
				pass_q <= 1'b0;
				cnt_q  <= 3'd0;
				rem_q  <= 5'd0;
				res_q  <= '{found: 1'b0, status: hssb_pkg::ST_DONE, fill_after: 5'd0};
			end
			hssb_pkg::S_MUL: begin
				part_q <= part_q + 2'd1;
				if (part_q == 2'd3) begin
					acc_q  <= '0;
					pass_q <= 1'b1;
					z_q    <= pass_q ? (mul_sum ^ (mul_sum >> 31)) : mul_sum;
				end else
					acc_q <= mul_sum;
			end
			hssb_pkg::S_MOD: begin
				rem_q <= rem_d;
				z_q   <= z_q << 8;
				cnt_q <= cnt_q + 3'd1;
			end
			hssb_pkg::S_FILL: begin
				bkt_q <= rem_q[hssb_pkg::BW-1:0];
				len_q <= fill_sel;
				lo_q  <= '0;
				hi_q  <= fill_sel;
			end
			hssb_pkg::S_SRCH_RD: idx_q <= mid;
			hssb_pkg::S_SRCH_CMP: begin
				if (rd_q < key_q) lo_q <= idx_q + 5'd1;
				else hi_q <= idx_q;
			end
			hssb_pkg::S_CHK_CMP: begin
				res_q.found <= hit;
				if (op_q == hssb_pkg::OP_ADD) begin
					idx_q <= len_q;
					if (hit) begin
						res_q.status     <= hssb_pkg::ST_NOCHG;
						res_q.fill_after <= len_q;
					end else if (len_q >= 5'(hssb_pkg::BUCKET_DEPTH)) begin
						res_q.status     <= hssb_pkg::ST_FULL;
						res_q.fill_after <= len_q;
					end else
						res_q.fill_after <= len_q + 5'd1;
				end else if (op_q == hssb_pkg::OP_DEL) begin
					idx_q <= lo_q;
					if (hit)
						res_q.fill_after <= len_q - 5'd1;
					else begin
						res_q.status     <= hssb_pkg::ST_NOCHG;
						res_q.fill_after <= len_q;
					end
				end else
					res_q.fill_after <= len_q;
			end
			hssb_pkg::S_SHIFT_WR: begin
				mem[{bkt_q, idx_q[hssb_pkg::DW-1:0]}] <= rd_q;
				idx_q <= (op_q == hssb_pkg::OP_ADD) ? idx_m1 : idx_p1;
			end
			hssb_pkg::S_INS: mem[{bkt_q, lo_q[hssb_pkg::DW-1:0]}] <= key_q;
			default: ;
		endcase
	end

	`HSSB_ASSERT_IMP(a_stall_busy, arst_n, state_q != hssb_pkg::S_IDLE, in_stall)
	`HSSB_ASSERT_IMP(a_full_nofill, arst_n, res_valid && res_q.status == hssb_pkg::ST_FULL,
		res_q.fill_after == 5'(hssb_pkg::BUCKET_DEPTH))
	`HSSB_ASSERT_NXT(a_res_hold, arst_n, res_valid && res_stall, res_valid && $stable(res_q))
	`HSSB_ASSERT_IMP(a_fill_range, arst_n, res_valid, res_q.fill_after <= 5'(hssb_pkg::BUCKET_DEPTH))
endmodule
`default_nettype wire
